### hw/rtl/srs_pkg.sv
// ----------------------------------------------------------------------------
// srs_pkg: shared types and constants of the selective-repeat sender
// Result item layout, input kind codes, register indexes and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package srs_pkg;

    // field and register widths fixed by the interface
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int KIND_W     = 2;
    localparam int SEQ_OUT_W  = 4;
    localparam int TIMER_W    = 16;

    // default window and sequence space
    localparam int WINDOW_DEF    = 8;
    localparam int SEQ_SPACE_DEF = 16;

    // most result items one input item may cause
    localparam int MAX_RESULTS = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b1;

    // input item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_START = 2'd0,
        KIND_ACK   = 2'd1,
        KIND_TICK  = 2'd2
    } t_kind;

    // one result item, without the last marker
    typedef struct packed {
        logic                 has_send;
        logic [SEQ_OUT_W-1:0] send_seq;
        logic                 relay_select;
        logic                 is_retransmit;
        logic                 final_packet;
        logic                 all_done;
    } t_result;

    // control from the sequencer to the result queue
    typedef struct packed {
        logic push;
        logic flush;
    } t_res_ctl;

endpackage

`default_nettype wire

### hw/rtl/srs_slot_ram.sv
// ----------------------------------------------------------------------------
// srs_slot_ram: per-slot timer and sequence store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module srs_slot_ram #(
    parameter  int DEPTH = 8,
    parameter  int DW    = 20,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hw/rtl/srs_result_q.sv
// ----------------------------------------------------------------------------
// srs_result_q: result holding stage and output register
// Holds the newest result back until the next one or the end of the item
// shows whether it is the last; caps results per item.
// ----------------------------------------------------------------------------
`default_nettype none

module srs_result_q (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire srs_pkg::t_res_ctl i_ctl,
    input  wire srs_pkg::t_result  i_res,
    output logic                   o_can_take,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output srs_pkg::t_result       o_res,
    output logic                   o_last
);

    import srs_pkg::*;

    localparam int CNT_W = $clog2(MAX_RESULTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RESULTS);

    logic             r_o_valid;
    logic             r_p_valid;
    logic [CNT_W-1:0] r_cnt;
    t_result          r_out;
    logic             r_last;
    t_result          r_pend;

    logic out_free;
    logic take;
    logic drain;
    logic load;

    // handshake decisions
    assign out_free   = !r_o_valid || i_ready;
    assign o_can_take = !r_p_valid || out_free;
    assign take       = i_ctl.push && o_can_take && (r_cnt < CNT_MAX);
    assign drain      = i_ctl.flush && r_p_valid && out_free;
    assign load       = (take && r_p_valid) || drain;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_p_valid <= 1'b0;
            r_cnt     <= '0;
        end else begin
            if (load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (take) begin
                r_p_valid <= 1'b1;
                r_cnt     <= r_cnt + 1'b1;
            end else if (drain) begin
                r_p_valid <= 1'b0;
            end
            if (i_ctl.flush && o_can_take) begin
                r_cnt <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out  <= r_pend;
            r_last <= drain;
        end
        if (take) begin
            r_pend <= i_res;
        end
    end

    assign o_valid = r_o_valid;
    assign o_res   = r_out;
    assign o_last  = r_last;

endmodule

`default_nettype wire

### hw/rtl/selective_repeat_sender_unit.sv
// ----------------------------------------------------------------------------
// selective_repeat_sender_unit: selective-repeat ARQ sender control path
// Sequencer over per-slot state kept in a one-port-read slot memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (i_kind, i_ack_seq) arrive on a valid/ready channel; a start
//   opens a transfer, an ack clears a window slot and may slide the base, a
//   tick ages every outstanding slot. Each send, retransmission or
//   completion leaves as a result item on the o_valid/i_ready channel, with
//   o_last on the final result of an input item.
//   Configuration writes (total packets, timeout ticks) go through i_cfg_we
//   while the block is idle.
//   Operation: one item is worked at a time. A tick visits every window
//   slot, and each outstanding slot is a read then a write-back of the slot
//   memory. A result passes the holding stage and the output register.
//   The next item is taken while the last result still waits in the output
//   register. A stalled receiver holds the sequencer once both the holding
//   stage and the output register are full.
//   Reset clears the transfer, the window and the output; total packets
//   resets to 1 and timeout ticks to 1000.
// ----------------------------------------------------------------------------
`default_nettype none

module selective_repeat_sender_unit #(
    parameter int WINDOW    = srs_pkg::WINDOW_DEF,
    parameter int SEQ_SPACE = srs_pkg::SEQ_SPACE_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [srs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [srs_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [srs_pkg::KIND_W-1:0]     i_kind,
    input  wire logic [srs_pkg::SEQ_OUT_W-1:0]  i_ack_seq,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic                                o_has_send,
    output logic      [srs_pkg::SEQ_OUT_W-1:0]  o_send_seq,
    output logic                                o_relay_select,
    output logic                                o_is_retransmit,
    output logic                                o_final_packet,
    output logic                                o_all_done,
    output logic                                o_last
);

    import srs_pkg::*;

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SQW    = $clog2(SEQ_SPACE);
    localparam int MW     = TIMER_W + SQW;

    localparam logic [CNT_W-1:0] WIN_CNT  = CNT_W'(WINDOW);
    localparam logic [SQW-1:0]   SEQ_LAST = SQW'(SEQ_SPACE - 1);
    localparam logic [SQW:0]     SPACE_X  = (SQW + 1)'(SEQ_SPACE);
    localparam logic [8:0]       SPACE_9  = 9'(SEQ_SPACE);

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_START   = 7'b0000010,
        ST_SLIDE   = 7'b0000100,
        ST_DONE    = 7'b0001000,
        ST_TICK_RD = 7'b0010000,
        ST_TICK_WR = 7'b0100000,
        ST_FLUSH   = 7'b1000000
    } t_state;

    // sequence arithmetic modulo the sequence space
    function automatic logic [SQW-1:0] seq_inc(input logic [SQW-1:0] a);
        return (a == SEQ_LAST) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [SQW-1:0] seq_dist(input logic [SQW-1:0] a,
                                                input logic [SQW-1:0] b);
        logic [SQW:0] d;
        d = (a >= b) ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + SPACE_X - {1'b0, b});
        return d[SQW-1:0];
    endfunction

    t_state              r_state, n_state;
    logic [CFG_W-1:0]    r_total;
    logic [CFG_W-1:0]    r_timeout;
    logic [WINDOW-1:0]   r_outst, n_outst;
    logic [SQW-1:0]      r_base, n_base;
    logic [SQW-1:0]      r_next, n_next;
    logic [CFG_W-1:0]    r_made, n_made;
    logic                r_active, n_active;
    logic [CNT_W-1:0]    r_i, n_i;

    logic [SLOT_W-1:0]   slot_of [SEQ_SPACE];
    logic [SLOT_W-1:0]   base_slot;
    logic [SLOT_W-1:0]   next_slot;
    logic [SLOT_W-1:0]   ack_slot;
    logic [SQW-1:0]      ack_s;
    logic                ack_in_space;
    logic                in_win;
    logic                more;
    logic [CFG_W-1:0]    made_inc;
    logic [SQW-1:0]      last_seq;
    logic [SQW-1:0]      base_inc;
    logic [SQW-1:0]      slide_next;

    logic                mem_we;
    logic [SLOT_W-1:0]   mem_waddr;
    logic [MW-1:0]       mem_wdata;
    logic                mem_re;
    logic [MW-1:0]       mem_rdata;
    logic [TIMER_W-1:0]  rd_timer;
    logic [SQW-1:0]      rd_seq;

    logic                do_send;
    t_res_ctl            res_ctl;
    t_result             res;
    t_result             out_res;
    logic                can_take;

    // slot of every sequence number, worked out at elaboration
    for (genvar g = 0; g < SEQ_SPACE; g++) begin : g_slot
        assign slot_of[g] = SLOT_W'(g % WINDOW);
    end

    // window decode
    assign base_slot    = slot_of[r_base];
    assign next_slot    = slot_of[r_next];
    assign ack_s        = SQW'(i_ack_seq);
    assign ack_slot     = slot_of[ack_s];
    assign ack_in_space = ({5'b0, i_ack_seq} < SPACE_9);
    assign in_win       = ack_in_space && (seq_dist(ack_s, r_base) < seq_dist(r_next, r_base));
    assign more         = r_made < r_total;
    assign made_inc     = r_made + 1'b1;
    assign last_seq     = (r_next == '0) ? SEQ_LAST : r_next - 1'b1;
    assign base_inc     = seq_inc(r_base);
    assign slide_next   = more ? seq_inc(r_next) : r_next;
    assign rd_timer     = mem_rdata[MW-1:SQW];
    assign rd_seq       = mem_rdata[SQW-1:0];

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_outst    = r_outst;
        n_base     = r_base;
        n_next     = r_next;
        n_made     = r_made;
        n_active   = r_active;
        n_i        = r_i;
        do_send    = 1'b0;
        res_ctl    = '0;
        res        = '0;
        mem_we     = 1'b0;
        mem_waddr  = next_slot;
        mem_wdata  = {r_timeout, r_next};
        mem_re     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    case (i_kind)
                        KIND_START: begin
                            if (!r_active && (r_total != '0)) begin
                                n_outst  = '0;
                                n_base   = '0;
                                n_next   = '0;
                                n_made   = '0;
                                n_active = 1'b1;
                                n_i      = '0;
                                n_state  = ST_START;
                            end
                        end
                        KIND_ACK: begin
                            if (r_active && in_win) begin
                                n_outst[ack_slot] = 1'b0;
                                if (ack_s == r_base) begin
                                    n_state = ST_SLIDE;
                                end
                            end
                        end
                        KIND_TICK: begin
                            if (r_active) begin
                                n_i     = '0;
                                n_state = ST_TICK_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_START: begin
                if (can_take) begin
                    if ((r_i < WIN_CNT) && more) begin
                        do_send = 1'b1;
                        n_i     = r_i + 1'b1;
                    end else begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_SLIDE: begin
                if (can_take) begin
                    if (r_outst[base_slot]) begin
                        n_state = ST_DONE;
                    end else begin
                        n_base  = base_inc;
                        do_send = more;
                        if (base_inc == slide_next) begin
                            n_state = ST_DONE;
                        end
                    end
                end
            end
            ST_DONE: begin
                if (can_take) begin
                    if (!more && (r_base == r_next)) begin
                        n_active     = 1'b0;
                        res_ctl.push = 1'b1;
                        res.all_done = 1'b1;
                    end
                    n_state = ST_FLUSH;
                end
            end
            ST_TICK_RD: begin
                if (r_i == WIN_CNT) begin
                    n_state = ST_FLUSH;
                end else if (r_outst[r_i[SLOT_W-1:0]]) begin
                    mem_re  = 1'b1;
                    n_state = ST_TICK_WR;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            ST_TICK_WR: begin
                if (can_take) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_i[SLOT_W-1:0];
                    if (rd_timer <= TIMER_W'(1)) begin
                        mem_wdata         = {r_timeout, rd_seq};
                        res_ctl.push      = 1'b1;
                        res.has_send      = 1'b1;
                        res.send_seq      = SEQ_OUT_W'(rd_seq);
                        res.relay_select  = ~rd_seq[0];
                        res.is_retransmit = 1'b1;
                        res.final_packet  = !more && (rd_seq == last_seq);
                    end else begin
                        mem_wdata = {rd_timer - 1'b1, rd_seq};
                    end
                    n_i     = r_i + 1'b1;
                    n_state = ST_TICK_RD;
                end
            end
            ST_FLUSH: begin
                res_ctl.flush = 1'b1;
                if (can_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // first send of a new packet
        if (do_send) begin
            n_outst[next_slot] = 1'b1;
            mem_we             = 1'b1;
            mem_waddr          = next_slot;
            mem_wdata          = {r_timeout, r_next};
            n_next             = seq_inc(r_next);
            n_made             = made_inc;
            res_ctl.push       = 1'b1;
            res.has_send       = 1'b1;
            res.send_seq       = SEQ_OUT_W'(r_next);
            res.relay_select   = ~r_next[0];
            res.final_packet   = (made_inc == r_total);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_outst   <= '0;
            r_base    <= '0;
            r_next    <= '0;
            r_made    <= '0;
            r_active  <= 1'b0;
            r_i       <= '0;
            r_total   <= CFG_W'(1);
            r_timeout <= CFG_W'(1000);
        end else begin
            r_state  <= n_state;
            r_outst  <= n_outst;
            r_base   <= n_base;
            r_next   <= n_next;
            r_made   <= n_made;
            r_active <= n_active;
            r_i      <= n_i;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TOTAL:   r_total   <= i_cfg_data;
                    CFG_TIMEOUT: r_timeout <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // slot timer and sequence memory
    srs_slot_ram #(
        .DEPTH (WINDOW),
        .DW    (MW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_i[SLOT_W-1:0]),
        .o_rdata (mem_rdata)
    );

    // result holding stage and output register
    srs_result_q u_resq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (res_ctl),
        .i_res      (res),
        .o_can_take (can_take),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_res      (out_res),
        .o_last     (o_last)
    );

    // no item is taken while reset is held
    assign o_ready         = (r_state == ST_IDLE) && i_rst_n;
    assign o_has_send      = out_res.has_send;
    assign o_send_seq      = out_res.send_seq;
    assign o_relay_select  = out_res.relay_select;
    assign o_is_retransmit = out_res.is_retransmit;
    assign o_final_packet  = out_res.final_packet;
    assign o_all_done      = out_res.all_done;

endmodule

`default_nettype wire

### hw/rtl/srs_checker.sv
// ----------------------------------------------------------------------------
// srs_checker: port-level checks of the selective-repeat sender
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module srs_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic       o_has_send,
    input wire logic [3:0] o_send_seq,
    input wire logic       o_relay_select,
    input wire logic       o_is_retransmit,
    input wire logic       o_final_packet,
    input wire logic       o_all_done,
    input wire logic       o_last
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_send_seq) && $stable(o_has_send)
            && $stable(o_last) && $stable(o_all_done))
        else $error("result changed while stalled");

    // relay choice follows sequence parity on sends
    a_relay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_has_send |-> (o_relay_select == ~o_send_seq[0]) && !o_all_done)
        else $error("relay choice does not match sequence parity");

    // a result without a send is the completion item, blank otherwise
    a_done_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_has_send |-> o_all_done && !o_relay_select && !o_is_retransmit
            && !o_final_packet && (o_send_seq == 4'd0))
        else $error("malformed completion item");

    // completion always closes its input item
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_all_done |-> o_last)
        else $error("completion item not marked last");

endmodule

bind selective_repeat_sender_unit srs_checker u_srs_checker (.*);

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: selective_repeat_sender_unit self-checking bench
// Drives start, ack and tick items into the sender and checks every result
// item against a cycle-free model of the ARQ window kept in the bench. A short
// table of directed items covers idle, window-edge and completion cases, then
// random phases with varied idling, register settings and one long receiver
// hold-off that backs the block up.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import srs_pkg::*;

    localparam int                WIN          = WINDOW_DEF;
    localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;
    localparam int                DRAIN_CYCLES = 40;
    localparam int                HOLD_CYCLES  = 600;
    localparam int                CYCLE_LIMIT  = 400000;

    // expected result item: fields plus the last marker
    typedef struct packed {
        t_result r;
        logic    last;
    } t_res_item;

    // one row of stimulus: an item or a register write
    typedef struct packed {
        logic                 is_cfg;
        logic [KIND_W-1:0]    kind;
        logic [SEQ_OUT_W-1:0] seq;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        logic                 typed;
        logic                 one_result;
        t_res_item            want;
    } t_stim_row;

    // dut ports
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 i_valid     = 1'b0;
    logic                 o_ready;
    logic [KIND_W-1:0]    i_kind      = '0;
    logic [SEQ_OUT_W-1:0] i_ack_seq   = '0;
    logic                 o_valid;
    logic                 i_ready     = 1'b0;
    logic                 o_has_send;
    logic [SEQ_OUT_W-1:0] o_send_seq;
    logic                 o_relay_select;
    logic                 o_is_retransmit;
    logic                 o_final_packet;
    logic                 o_all_done;
    logic                 o_last;

    // bench control
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_asks    = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int fails        = 0;
    int cycles       = 0;

    t_res_item results_due[$];
    t_res_item step_out[$];
    t_stim_row directed[$];

    // model of the window
    logic [CFG_W-1:0]     total_pkts  = 16'd1;
    logic [CFG_W-1:0]     timeout_val = 16'd1000;
    logic                 outst[WIN];
    logic [TIMER_W-1:0]   pkt_timer[WIN];
    logic [SEQ_OUT_W-1:0] pkt_seq[WIN];
    logic [SEQ_OUT_W-1:0] base = '0;
    logic [SEQ_OUT_W-1:0] nxt  = '0;
    logic [15:0]          made = '0;
    logic                 busy = 1'b0;

    selective_repeat_sender_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_kind          (i_kind),
        .i_ack_seq       (i_ack_seq),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_has_send      (o_has_send),
        .o_send_seq      (o_send_seq),
        .o_relay_select  (o_relay_select),
        .o_is_retransmit (o_is_retransmit),
        .o_final_packet  (o_final_packet),
        .o_all_done      (o_all_done),
        .o_last          (o_last)
    );

    // clock
    always #2 i_clk = ~i_clk;

    // window model: result building
    function automatic logic packets_left();
        return made < total_pkts;
    endfunction

    task automatic post_result(input logic has, input logic [SEQ_OUT_W-1:0] s,
                               input logic retx, input logic fin, input logic done);
        t_res_item e;
        if (step_out.size() < MAX_RESULTS) begin
            e.r.has_send      = has;
            e.r.send_seq      = s;
            e.r.relay_select  = has & ~s[0];
            e.r.is_retransmit = retx;
            e.r.final_packet  = fin;
            e.r.all_done      = done;
            e.last            = 1'b0;
            step_out.push_back(e);
        end
    endtask

    task automatic launch_packet();
        logic [SEQ_OUT_W-1:0] s;
        int                   slot;
        s    = nxt;
        slot = s % WIN;
        nxt  = nxt + 1'b1;
        made = made + 16'd1;
        outst[slot]     = 1'b1;
        pkt_seq[slot]   = s;
        pkt_timer[slot] = timeout_val;
        post_result(1'b1, s, 1'b0, made == total_pkts, 1'b0);
    endtask

    // window model: one input item, results land in step_out
    task automatic arq_step(input logic [KIND_W-1:0] k, input logic [SEQ_OUT_W-1:0] s);
        logic [SEQ_OUT_W-1:0] off;
        logic [SEQ_OUT_W-1:0] span;
        logic [SEQ_OUT_W-1:0] newest;
        logic                 sliding;
        t_res_item            tail;
        int                   i;
        step_out.delete();
        case (k)
            KIND_START: begin
                if (!busy && total_pkts != 0) begin
                    for (i = 0; i < WIN; i++) begin
                        outst[i]     = 1'b0;
                        pkt_timer[i] = '0;
                        pkt_seq[i]   = '0;
                    end
                    base = '0;
                    nxt  = '0;
                    made = '0;
                    busy = 1'b1;
                    for (i = 0; i < WIN && packets_left(); i++) launch_packet();
                end
            end
            KIND_ACK: begin
                if (busy) begin
                    off  = s - base;
                    span = nxt - base;
                    if (off < span) begin
                        outst[s % WIN] = 1'b0;
                        // slide over cleared slots, one new packet per step while packets remain
                        if (s == base) begin
                            sliding = 1'b1;
                            while (sliding) begin
                                if (outst[base % WIN]) begin
                                    sliding = 1'b0;
                                end else begin
                                    base = base + 1'b1;
                                    if (packets_left()) launch_packet();
                                    if (base == nxt) sliding = 1'b0;
                                end
                            end
                        end
                        if (!packets_left() && base == nxt) begin
                            busy = 1'b0;
                            post_result(1'b0, '0, 1'b0, 1'b0, 1'b1);
                        end
                    end
                end
            end
            KIND_TICK: begin
                if (busy) begin
                    newest = nxt - 1'b1;
                    for (i = 0; i < WIN; i++) begin
                        if (outst[i]) begin
                            if (pkt_timer[i] <= 1) begin
                                pkt_timer[i] = timeout_val;
                                post_result(1'b1, pkt_seq[i], 1'b1,
                                            !packets_left() && pkt_seq[i] == newest, 1'b0);
                            end else begin
                                pkt_timer[i] = pkt_timer[i] - 1'b1;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        if (step_out.size() > 0) begin
            tail      = step_out.pop_back();
            tail.last = 1'b1;
            step_out.push_back(tail);
        end
    endtask

    // row builders
    function automatic t_res_item mk_res(logic has, logic [SEQ_OUT_W-1:0] s, logic relay,
                                         logic retx, logic fin, logic done, logic lst);
        t_res_item e;
        e.r.has_send      = has;
        e.r.send_seq      = s;
        e.r.relay_select  = relay;
        e.r.is_retransmit = retx;
        e.r.final_packet  = fin;
        e.r.all_done      = done;
        e.last            = lst;
        return e;
    endfunction

    function automatic t_stim_row item_row(logic [KIND_W-1:0] k, logic [SEQ_OUT_W-1:0] s);
        t_stim_row row;
        row      = '0;
        row.kind = k;
        row.seq  = s;
        return row;
    endfunction

    function automatic t_stim_row quiet_row(logic [KIND_W-1:0] k, logic [SEQ_OUT_W-1:0] s);
        t_stim_row row;
        row       = item_row(k, s);
        row.typed = 1'b1;
        return row;
    endfunction

    function automatic t_stim_row typed_row(logic [KIND_W-1:0] k, logic [SEQ_OUT_W-1:0] s,
                                            t_res_item want);
        t_stim_row row;
        row            = quiet_row(k, s);
        row.one_result = 1'b1;
        row.want       = want;
        return row;
    endfunction

    function automatic t_stim_row cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        t_stim_row row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.data   = data;
        return row;
    endfunction

    // random item, mostly well formed against the current window
    function automatic t_stim_row random_row();
        int                   r;
        logic [SEQ_OUT_W-1:0] span;
        logic [KIND_W-1:0]    k;
        logic [SEQ_OUT_W-1:0] s;
        r    = $urandom_range(99);
        span = nxt - base;
        k    = KIND_TICK;
        s    = SEQ_OUT_W'($urandom_range(15));
        if (r >= 85) begin
            k = KIND_W'($urandom_range(3));
        end else if (!busy) begin
            k = KIND_START;
        end else if (r < 60 && span != 0) begin
            k = KIND_ACK;
            s = (r < 30) ? base : SEQ_OUT_W'(base + $urandom_range(span - 1));
        end
        return item_row(k, s);
    endfunction

    // offer one item, predict at acceptance
    task automatic put_item(input t_stim_row row);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_valid   <= 1'b1;
        i_kind    <= row.kind;
        i_ack_seq <= row.seq;
        do @(posedge i_clk); while (!o_ready);
        arq_step(row.kind, row.seq);
        if (row.typed) begin
            if (row.one_result) results_due.push_back(row.want);
        end else begin
            foreach (step_out[j]) results_due.push_back(step_out[j]);
        end
    endtask

    // wait until every result is in and the block has gone quiet
    task automatic settle();
        i_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_TOTAL) total_pkts = data;
        else timeout_val = data;
        @(posedge i_clk);
    endtask

    task automatic run_phase(input int tx, input int rx, input logic [CFG_W-1:0] total,
                             input logic [CFG_W-1:0] tmo, input int n, input logic press);
        settle();
        write_reg(CFG_TOTAL, total);
        write_reg(CFG_TIMEOUT, tmo);
        tx_idle_pct  = tx;
        rx_stall_pct = rx;
        if (press) hold_asks++;
        repeat (n) put_item(random_row());
    endtask

    // receiver: random stalls, or a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s expected %0d actual %0d", name, want, got);
            fails++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_res_item e;
        if (i_rst_n && o_valid && i_ready) begin
            if (results_due.size() == 0) begin
                $error("result item with none expected, send_seq %0d", o_send_seq);
                fails++;
            end else begin
                e = results_due.pop_front();
                check_field("has_send", e.r.has_send, o_has_send);
                check_field("send_seq", e.r.send_seq, o_send_seq);
                check_field("relay_select", e.r.relay_select, o_relay_select);
                check_field("is_retransmit", e.r.is_retransmit, o_is_retransmit);
                check_field("final_packet", e.r.final_packet, o_final_packet);
                check_field("all_done", e.r.all_done, o_all_done);
                check_field("last", e.last, o_last);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[selective_repeat_sender_unit] ERROR");
            $finish;
        end
    end

    initial begin
        // idle and single-packet cases after reset
        directed.push_back(quiet_row(KIND_TICK, 4'd0));
        directed.push_back(quiet_row(KIND_ACK, 4'd0));
        directed.push_back(quiet_row(KIND_UNUSED, 4'd15));
        directed.push_back(typed_row(KIND_START, 4'd0,
                                     mk_res(1'b1, 4'd0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1)));
        directed.push_back(quiet_row(KIND_START, 4'd0));
        directed.push_back(quiet_row(KIND_ACK, 4'd5));
        directed.push_back(typed_row(KIND_ACK, 4'd0,
                                     mk_res(1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1)));
        // zero-length transfer stays idle
        directed.push_back(cfg_row(CFG_TOTAL, 16'd0));
        directed.push_back(quiet_row(KIND_START, 4'd0));
        // full window, zero timeout, then slides
        directed.push_back(cfg_row(CFG_TOTAL, 16'd12));
        directed.push_back(cfg_row(CFG_TIMEOUT, 16'd0));
        directed.push_back(item_row(KIND_START, 4'd0));
        directed.push_back(item_row(KIND_TICK, 4'd0));
        directed.push_back(cfg_row(CFG_TIMEOUT, 16'hFFFF));
        directed.push_back(quiet_row(KIND_ACK, 4'd3));
        directed.push_back(item_row(KIND_ACK, 4'd0));
        directed.push_back(item_row(KIND_ACK, 4'd1));
        directed.push_back(item_row(KIND_ACK, 4'd2));
        directed.push_back(quiet_row(KIND_ACK, 4'd15));
        directed.push_back(item_row(KIND_TICK, 4'd0));
        // total lowered below packets made, then ack out to completion
        directed.push_back(cfg_row(CFG_TOTAL, 16'd10));
        directed.push_back(item_row(KIND_ACK, 4'd4));
        directed.push_back(item_row(KIND_ACK, 4'd6));
        directed.push_back(item_row(KIND_ACK, 4'd5));
        directed.push_back(item_row(KIND_ACK, 4'd7));
        directed.push_back(item_row(KIND_ACK, 4'd8));
        directed.push_back(item_row(KIND_ACK, 4'd9));
        directed.push_back(item_row(KIND_ACK, 4'd10));
        directed.push_back(item_row(KIND_ACK, 4'd11));

        for (int i = 0; i < WIN; i++) begin
            outst[i]     = 1'b0;
            pkt_timer[i] = '0;
            pkt_seq[i]   = '0;
        end

        // reset
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (directed[i]) begin
            if (directed[i].is_cfg) begin
                settle();
                write_reg(directed[i].idx, directed[i].data);
            end else begin
                put_item(directed[i]);
            end
        end

        // random phases: idling mix, totals, timeouts, one hold-off
        run_phase(0, 0, 16'd20, 16'd3, 60, 1'b0);
        run_phase(54, 0, 16'd9, 16'd1, 60, 1'b0);
        run_phase(0, 54, 16'd30, 16'd8, 60, 1'b0);
        run_phase(36, 36, 16'd16, 16'd2, 60, 1'b0);
        run_phase(0, 0, 16'hFFFF, 16'd5, 50, 1'b1);
        run_phase(0, 0, 16'd3, 16'd4, 70, 1'b0);

        settle();
        if (fails == 0) begin
            $display("[selective_repeat_sender_unit] OK");
        end else begin
            $display("[selective_repeat_sender_unit] ERROR");
        end
        $finish;
    end

endmodule
